>>> hw/rtl/afpf_pkg.sv
// afpf_pkg: shared types, codes and helpers of the pattern fill pixel test
// no dependencies; imported by every module of the block
`default_nettype none

package afpf_pkg;

  localparam int COORD_W = 16;
  localparam int SIZE_W  = 15;
  localparam int INDEX_W = 12;
  localparam int TILE_W  = 7;
  localparam int REG_W   = 32;
  localparam int CELL_W  = 17;
  localparam int QDEPTH  = 4;
  localparam int QCNT_W  = 3;
  localparam int REM_W   = 4;

  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_RECT   = 2'd1;
  localparam logic [1:0] MODE_DISC   = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [2:0] CFG_INV_A  = 3'd0;
  localparam logic [2:0] CFG_INV_B  = 3'd1;
  localparam logic [2:0] CFG_INV_C  = 3'd2;
  localparam logic [2:0] CFG_INV_D  = 3'd3;
  localparam logic [2:0] CFG_INV_E  = 3'd4;
  localparam logic [2:0] CFG_INV_F  = 3'd5;
  localparam logic [2:0] CFG_TILE_W = 3'd6;
  localparam logic [2:0] CFG_TILE_H = 3'd7;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_RECT,
    KIND_DISC
  } kind_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] shx;
    logic signed [COORD_W-1:0] shy;
    logic [SIZE_W-1:0]         sw;
    logic [SIZE_W-1:0]         sh;
    logic                      white;
    logic                      pat;
    logic [INDEX_W-1:0]        li;
    logic                      lb;
  } item_fields_t;

  typedef struct packed {
    kind_t        kind;
    item_fields_t f;
  } item_meta_t;

  // four restoring remainder steps, msb of bits first
  function automatic logic [TILE_W-1:0] rem_step(input logic [TILE_W-1:0] rem,
                                                 input logic [REM_W-1:0] bits,
                                                 input logic [TILE_W-1:0] div);
    logic [TILE_W:0]   r;
    logic [TILE_W-1:0] q;
    q = rem;
    for (int i = REM_W - 1; i >= 0; i--) begin
      r = {q, bits[i]};
      if (r >= {1'b0, div}) begin
        r = r - {1'b0, div};
      end
      q = r[TILE_W-1:0];
    end
    return q;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/affine_pattern_fill_pixel_test_top.sv
// path from an accepted request to out_tvalid at default parameters: 2 front
// registers, the first loaded on the accepting edge, a queue write, 15 back
// stages and 1 result register
// throughput: one item per clock while out_tready keeps up; the back pipeline is fully pipelined
// reset: rst_n synchronous active low, clears control state and loads the
// identity matrix and an empty tile; pattern store contents undefined until loaded
// depends on afpf_pkg, afpf_front, afpf_fifo, afpf_back
`default_nettype none

module affine_pattern_fill_pixel_test_top import afpf_pkg::*; #(
  parameter int PATTERN_CELLS = 4096,
  parameter int PIXEL_BITS    = 10,
  parameter int FRAC_BITS     = 16
) (
  input  logic clk,
  input  logic rst_n,
  // input request channel
  input  logic in_tvalid,
  output logic in_tready,
  // tdata from bit 0: pixel_x, pixel_y, shape_x, shape_y, shape_w, shape_h,
  // fill_white, use_pattern, load_index, load_bit, zero padding
  input  logic [((2*PIXEL_BITS+77+7)/8)*8-1:0] in_tdata,
  // tuser: mode
  input  logic [1:0] in_tuser,
  // result channel
  output logic out_tvalid,
  input  logic out_tready,
  // tdata from bit 0: out_x, out_y, out_white, zero padding
  output logic [((2*PIXEL_BITS+1+7)/8)*8-1:0] out_tdata,
  // configuration writes
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [REG_W-1:0] cfg_data
);

  localparam int P     = PIXEL_BITS;
  localparam int LW    = (P + 36 > FRAC_BITS + 19) ? P + 36 : FRAC_BITS + 19;
  localparam int OUT_W = ((2 * P + 1 + 7) / 8) * 8;
  localparam int QW_D  = $bits(item_meta_t) + 2 * P + 2 * LW;
  localparam int B     = 2 * P;

  // configuration registers
  logic signed [REG_W-1:0] inv_a_r, inv_b_r, inv_c_r, inv_d_r, inv_e_r, inv_f_r;
  logic [TILE_W-1:0]       tile_w_r, tile_h_r;

  // unpacked request fields
  logic [P-1:0]  in_px, in_py;
  item_fields_t  in_fields;

  // front to queue
  logic                 push;
  item_meta_t           push_meta;
  logic [P-1:0]         push_px, push_py;
  logic signed [LW-1:0] push_lx, push_ly;
  logic [QCNT_W-1:0]    fifo_cnt;

  // queue to back
  logic [QW_D-1:0]      q_dout;
  logic                 q_valid, q_pop;
  item_meta_t           q_meta;
  logic [P-1:0]         q_px, q_py;
  logic signed [LW-1:0] q_lx, q_ly;

  logic [P-1:0] res_x, res_y;
  logic         res_white;

  // config writes are always taken; software writes only while idle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_a_r  <= REG_W'(65536);
      inv_b_r  <= '0;
      inv_c_r  <= '0;
      inv_d_r  <= REG_W'(65536);
      inv_e_r  <= '0;
      inv_f_r  <= '0;
      tile_w_r <= '0;
      tile_h_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_INV_A:  inv_a_r  <= cfg_data;
        CFG_INV_B:  inv_b_r  <= cfg_data;
        CFG_INV_C:  inv_c_r  <= cfg_data;
        CFG_INV_D:  inv_d_r  <= cfg_data;
        CFG_INV_E:  inv_e_r  <= cfg_data;
        CFG_INV_F:  inv_f_r  <= cfg_data;
        CFG_TILE_W: tile_w_r <= cfg_data[TILE_W-1:0];
        CFG_TILE_H: tile_h_r <= cfg_data[TILE_W-1:0];
      endcase
    end
  end

  // split the request word into its fields
  assign in_px           = in_tdata[P-1:0];
  assign in_py           = in_tdata[2*P-1:P];
  assign in_fields.shx   = in_tdata[B+15:B];
  assign in_fields.shy   = in_tdata[B+31:B+16];
  assign in_fields.sw    = in_tdata[B+46:B+32];
  assign in_fields.sh    = in_tdata[B+61:B+47];
  assign in_fields.white = in_tdata[B+62];
  assign in_fields.pat   = in_tdata[B+63];
  assign in_fields.li    = in_tdata[B+75:B+64];
  assign in_fields.lb    = in_tdata[B+76];

  // front: classification and inverse mapping of the pixel centre
  afpf_front #(
    .PATTERN_CELLS(PATTERN_CELLS),
    .PIXEL_BITS   (P),
    .LW           (LW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .mode     (in_tuser),
    .px       (in_px),
    .py       (in_py),
    .fields   (in_fields),
    .inv_a    (inv_a_r),
    .inv_b    (inv_b_r),
    .inv_c    (inv_c_r),
    .inv_d    (inv_d_r),
    .inv_e    (inv_e_r),
    .inv_f    (inv_f_r),
    .fifo_cnt (fifo_cnt),
    .push     (push),
    .push_meta(push_meta),
    .push_px  (push_px),
    .push_py  (push_py),
    .push_lx  (push_lx),
    .push_ly  (push_ly)
  );

  // queue decouples front credit from back-pressure on the result side
  afpf_fifo #(
    .W    (QW_D),
    .DEPTH(QDEPTH)
  ) u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .din  ({push_meta, push_px, push_py, push_lx, push_ly}),
    .pop  (q_pop),
    .dout (q_dout),
    .valid(q_valid),
    .cnt  (fifo_cnt)
  );

  assign {q_meta, q_px, q_py, q_lx, q_ly} = q_dout;

  // back: coverage, pattern cell, pattern store, result register
  afpf_back #(
    .PATTERN_CELLS(PATTERN_CELLS),
    .PIXEL_BITS   (P),
    .FRAC_BITS    (FRAC_BITS),
    .LW           (LW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fifo_valid(q_valid),
    .fifo_pop  (q_pop),
    .in_meta   (q_meta),
    .in_px     (q_px),
    .in_py     (q_py),
    .in_lx     (q_lx),
    .in_ly     (q_ly),
    .tile_w    (tile_w_r),
    .tile_h    (tile_h_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_x     (res_x),
    .out_y     (res_y),
    .out_white (res_white)
  );

  assign out_tdata = OUT_W'({res_white, res_y, res_x});

endmodule

`default_nettype wire

>>> hw/rtl/afpf_front.sv
// afpf_front: accepts items, classifies them and maps the pixel centre
// through the inverse matrix; depends on afpf_pkg
`default_nettype none

module afpf_front import afpf_pkg::*; #(
  parameter int PATTERN_CELLS = 4096,
  parameter int PIXEL_BITS    = 10,
  parameter int LW            = 46
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              mode,
  input  logic [PIXEL_BITS-1:0]   px,
  input  logic [PIXEL_BITS-1:0]   py,
  input  item_fields_t            fields,
  input  logic signed [REG_W-1:0] inv_a,
  input  logic signed [REG_W-1:0] inv_b,
  input  logic signed [REG_W-1:0] inv_c,
  input  logic signed [REG_W-1:0] inv_d,
  input  logic signed [REG_W-1:0] inv_e,
  input  logic signed [REG_W-1:0] inv_f,
  input  logic [QCNT_W-1:0]       fifo_cnt,
  output logic                    push,
  output item_meta_t              push_meta,
  output logic [PIXEL_BITS-1:0]   push_px,
  output logic [PIXEL_BITS-1:0]   push_py,
  output logic signed [LW-1:0]    push_lx,
  output logic signed [LW-1:0]    push_ly
);

  localparam int PW = REG_W + PIXEL_BITS + 2;

  logic                        accept;
  logic                        keep;
  kind_t                       kind;
  logic [QCNT_W:0]             occ;
  logic signed [PIXEL_BITS+1:0] sx2;
  logic signed [PIXEL_BITS+1:0] sy2;

  logic                     v1_r, v2_r;
  item_meta_t               meta1_r, meta2_r;
  logic [PIXEL_BITS-1:0]    px1_r, py1_r, px2_r, py2_r;
  logic signed [PW-1:0]     pa_r, pb_r, pc_r, pd_r;
  logic signed [REG_W-1:0]  e_r, f_r;
  logic signed [LW-1:0]     lx_r, ly_r;

  // items in flight plus queue fill never exceed the queue depth
  assign occ      = {1'b0, fifo_cnt} + (QCNT_W+1)'(v1_r) + (QCNT_W+1)'(v2_r);
  assign in_ready = occ < (QCNT_W+1)'(QDEPTH);
  assign accept   = in_valid && in_ready;

  assign sx2 = $signed({1'b0, px, 1'b1});
  assign sy2 = $signed({1'b0, py, 1'b1});

  always_comb begin
    kind = KIND_LOAD;
    keep = 1'b0;
    unique case (mode)
      MODE_LOAD: begin
        kind = KIND_LOAD;
        keep = CELL_W'(fields.li) < CELL_W'(PATTERN_CELLS);
      end
      MODE_RECT: begin
        kind = KIND_RECT;
        keep = (fields.sw != '0) && (fields.sh != '0);
      end
      MODE_DISC: begin
        kind = KIND_DISC;
        keep = fields.sw != '0;
      end
      default: begin
        kind = KIND_LOAD;
        keep = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= accept && keep;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    meta1_r.kind <= kind;
    meta1_r.f    <= fields;
    px1_r        <= px;
    py1_r        <= py;
    pa_r         <= inv_a * sx2;
    pb_r         <= inv_b * sx2;
    pc_r         <= inv_c * sy2;
    pd_r         <= inv_d * sy2;
    e_r          <= inv_e;
    f_r          <= inv_f;
    meta2_r      <= meta1_r;
    px2_r        <= px1_r;
    py2_r        <= py1_r;
    lx_r         <= LW'(pa_r) + LW'(pc_r) + (LW'(e_r) <<< 1);
    ly_r         <= LW'(pb_r) + LW'(pd_r) + (LW'(f_r) <<< 1);
  end

  assign push      = v2_r;
  assign push_meta = meta2_r;
  assign push_px   = px2_r;
  assign push_py   = py2_r;
  assign push_lx   = lx_r;
  assign push_ly   = ly_r;

endmodule

`default_nettype wire

>>> hw/rtl/afpf_fifo.sv
// afpf_fifo: short queue between the front and back parts
// depends on afpf_pkg for the count width
`default_nettype none

module afpf_fifo import afpf_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [W-1:0]      din,
  input  logic              pop,
  output logic [W-1:0]      dout,
  output logic              valid,
  output logic [QCNT_W-1:0] cnt
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]      mem_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  assign dout  = mem_r[rd_ptr_r];
  assign valid = cnt_r != '0;
  assign cnt   = cnt_r;

endmodule

`default_nettype wire

>>> hw/rtl/afpf_back.sv
// afpf_back: coverage test, pattern cell lookup, pattern store and result register
// depends on afpf_pkg
`default_nettype none

module afpf_back import afpf_pkg::*; #(
  parameter int PATTERN_CELLS = 4096,
  parameter int PIXEL_BITS    = 10,
  parameter int FRAC_BITS     = 16,
  parameter int LW            = 46
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fifo_valid,
  output logic                  fifo_pop,
  input  item_meta_t            in_meta,
  input  logic [PIXEL_BITS-1:0] in_px,
  input  logic [PIXEL_BITS-1:0] in_py,
  input  logic signed [LW-1:0]  in_lx,
  input  logic signed [LW-1:0]  in_ly,
  input  logic [TILE_W-1:0]     tile_w,
  input  logic [TILE_W-1:0]     tile_h,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIXEL_BITS-1:0] out_x,
  output logic [PIXEL_BITS-1:0] out_y,
  output logic                  out_white
);

  localparam int SH1   = FRAC_BITS + 1;
  localparam int DW    = LW + 2;
  localparam int H     = (DW + 1) / 2;
  localparam int HW    = DW - H;
  localparam int SQW   = 2 * DW;
  localparam int QW    = LW - SH1;
  localparam int NDS   = (QW + REM_W - 1) / REM_W;
  localparam int DQ    = NDS * REM_W;
  localparam int S_HIT = 4;
  localparam int S_DIV = S_HIT + NDS;
  localparam int S_FIX = S_DIV + 1;
  localparam int S_IDX = S_FIX + 1;
  localparam int NST   = S_IDX + 1;
  localparam int R2W   = 2 * SIZE_W;
  localparam int AW    = (PATTERN_CELLS > 1) ? $clog2(PATTERN_CELLS) : 1;

  typedef struct packed {
    kind_t                 kind;
    logic [PIXEL_BITS-1:0] px;
    logic [PIXEL_BITS-1:0] py;
    logic                  white;
    logic                  pat;
    logic                  hit;
    logic                  inr;
    logic                  tz;
    logic [INDEX_W-1:0]    li;
    logic                  lb;
  } ctl_t;

  logic b_adv;

  // entry stage arithmetic
  logic signed [DW-1:0] lxw, lyw, x0, y0, wq, hq, dx, dy;
  logic [DW-1:0]        dxm, dym;
  logic [QW-1:0]        qx, qy;
  logic                 rect_hit;
  ctl_t                 ctl_in;

  logic [NST:1]    v_r;
  ctl_t            ctl_r [1:NST];
  ctl_t            ctl_nxt [1:NST];
  logic [DW-1:0]   dxm_r, dym_r;
  logic [R2W-1:0]  r2_r [1:3];
  logic [2*HW-1:0] hhx_r, hhy_r;
  logic [HW+H-1:0] hlx_r, hly_r;
  logic [2*H-1:0]  llx_r, lly_r;
  logic [SQW-1:0]  sqx_r, sqy_r;
  logic [DQ-1:0]   mx_r [1:S_DIV];
  logic [DQ-1:0]   my_r [1:S_DIV];
  logic [TILE_W-1:0] rx_r [1:S_DIV];
  logic [TILE_W-1:0] ry_r [1:S_DIV];
  logic [S_DIV:1]  nx_r, ny_r;
  logic [TILE_W-1:0] cx_r, cy_r;
  logic [CELL_W-1:0] idx_r;
  logic              mem_q_r;
  logic              pat_mem [PATTERN_CELLS];

  logic [SQW:0]      d2, r2w;
  logic              disc_hit;
  logic [CELL_W-1:0] idx_nxt, mem_addr;
  logic              res, colour;

  logic                  out_valid_r, out_white_r;
  logic [PIXEL_BITS-1:0] out_x_r, out_y_r;

  assign b_adv    = !out_valid_r || out_ready;
  assign fifo_pop = fifo_valid && b_adv;

  assign lxw = DW'(in_lx);
  assign lyw = DW'(in_ly);
  assign x0  = DW'(in_meta.f.shx) <<< SH1;
  assign y0  = DW'(in_meta.f.shy) <<< SH1;
  assign wq  = $signed(DW'(in_meta.f.sw)) <<< SH1;
  assign hq  = $signed(DW'(in_meta.f.sh)) <<< SH1;
  assign dx  = lxw - x0;
  assign dy  = lyw - y0;
  assign dxm = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign dym = dy[DW-1] ? DW'(-dy) : DW'(dy);
  assign rect_hit = (lxw >= x0) && (lxw < x0 + wq) && (lyw >= y0) && (lyw < y0 + hq);

  // floor of the logical position, split into sign and magnitude
  assign qx = in_lx[LW-1] ? QW'(0) - in_lx[LW-1:SH1] : in_lx[LW-1:SH1];
  assign qy = in_ly[LW-1] ? QW'(0) - in_ly[LW-1:SH1] : in_ly[LW-1:SH1];

  always_comb begin
    ctl_in       = '0;
    ctl_in.kind  = in_meta.kind;
    ctl_in.px    = in_px;
    ctl_in.py    = in_py;
    ctl_in.white = in_meta.f.white;
    ctl_in.pat   = in_meta.f.pat;
    ctl_in.hit   = rect_hit;
    ctl_in.li    = in_meta.f.li;
    ctl_in.lb    = in_meta.f.lb;
  end

  assign d2       = (SQW+1)'(sqx_r) + (SQW+1)'(sqy_r);
  assign r2w      = (SQW+1)'(r2_r[3]) << (2 * SH1);
  assign disc_hit = d2 <= r2w;
  assign idx_nxt  = CELL_W'(cy_r) * CELL_W'(tile_w) + CELL_W'(cx_r);
  assign mem_addr = (ctl_r[S_IDX].kind == KIND_LOAD) ? CELL_W'(ctl_r[S_IDX].li) : idx_r;

  // control shift with the disc verdict and the cell checks folded in
  always_comb begin
    ctl_nxt[1] = ctl_in;
    for (int i = 2; i <= NST; i++) begin
      ctl_nxt[i] = ctl_r[i-1];
    end
    if (ctl_r[S_HIT-1].kind == KIND_DISC) begin
      ctl_nxt[S_HIT].hit = disc_hit;
    end
    ctl_nxt[NST].inr = idx_r < CELL_W'(PATTERN_CELLS);
    ctl_nxt[NST].tz  = (tile_w == '0) || (tile_h == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (b_adv) begin
      v_r         <= {v_r[NST-1:1], fifo_pop};
      out_valid_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      for (int i = 1; i <= NST; i++) begin
        ctl_r[i] <= ctl_nxt[i];
      end

      // disc distance, squares cut into half-width partial products
      dxm_r   <= dxm;
      dym_r   <= dym;
      r2_r[1] <= in_meta.f.sw * in_meta.f.sw;
      r2_r[2] <= r2_r[1];
      r2_r[3] <= r2_r[2];
      hhx_r   <= dxm_r[DW-1:H] * dxm_r[DW-1:H];
      hlx_r   <= dxm_r[DW-1:H] * dxm_r[H-1:0];
      llx_r   <= dxm_r[H-1:0] * dxm_r[H-1:0];
      hhy_r   <= dym_r[DW-1:H] * dym_r[DW-1:H];
      hly_r   <= dym_r[DW-1:H] * dym_r[H-1:0];
      lly_r   <= dym_r[H-1:0] * dym_r[H-1:0];
      sqx_r   <= (SQW'(hhx_r) << (2 * H)) + (SQW'(hlx_r) << (H + 1)) + SQW'(llx_r);
      sqy_r   <= (SQW'(hhy_r) << (2 * H)) + (SQW'(hly_r) << (H + 1)) + SQW'(lly_r);

      // cell coordinate remainder lanes
      mx_r[1] <= DQ'(qx);
      my_r[1] <= DQ'(qy);
      rx_r[1] <= '0;
      ry_r[1] <= '0;
      nx_r[1] <= in_lx[LW-1];
      ny_r[1] <= in_ly[LW-1];
      for (int j = 2; j <= S_DIV; j++) begin
        nx_r[j] <= nx_r[j-1];
        ny_r[j] <= ny_r[j-1];
        if (j <= S_HIT) begin
          mx_r[j] <= mx_r[j-1];
          my_r[j] <= my_r[j-1];
          rx_r[j] <= rx_r[j-1];
          ry_r[j] <= ry_r[j-1];
        end else begin
          mx_r[j] <= mx_r[j-1] << REM_W;
          my_r[j] <= my_r[j-1] << REM_W;
          rx_r[j] <= rem_step(rx_r[j-1], mx_r[j-1][DQ-1 -: REM_W], tile_w);
          ry_r[j] <= rem_step(ry_r[j-1], my_r[j-1][DQ-1 -: REM_W], tile_h);
        end
      end

      // negative floor wraps to a non-negative cell
      cx_r  <= (nx_r[S_DIV] && rx_r[S_DIV] != '0) ? tile_w - rx_r[S_DIV] : rx_r[S_DIV];
      cy_r  <= (ny_r[S_DIV] && ry_r[S_DIV] != '0) ? tile_h - ry_r[S_DIV] : ry_r[S_DIV];
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && v_r[S_IDX] && ctl_r[S_IDX].kind == KIND_LOAD) begin
      pat_mem[mem_addr[AW-1:0]] <= ctl_r[S_IDX].lb;
    end
    if (b_adv) begin
      mem_q_r <= pat_mem[mem_addr[AW-1:0]];
    end
  end

  always_comb begin
    priority if (!ctl_r[NST].pat) begin
      colour = ctl_r[NST].white;
    end else if (ctl_r[NST].tz) begin
      colour = 1'b1;
    end else if (!ctl_r[NST].inr) begin
      colour = !ctl_r[NST].white;
    end else begin
      colour = !(mem_q_r ^ ctl_r[NST].white);
    end
  end

  assign res = v_r[NST] && (ctl_r[NST].kind != KIND_LOAD) && ctl_r[NST].hit;

  always_ff @(posedge clk) begin
    if (b_adv) begin
      out_x_r     <= ctl_r[NST].px;
      out_y_r     <= ctl_r[NST].py;
      out_white_r <= colour;
    end
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_white = out_white_r;

endmodule

`default_nettype wire

>>> sim/tb.sv
// tb: self-checking testbench for affine_pattern_fill_pixel_test_top
// depends on afpf_pkg and the rtl of the block; reads no files
`timescale 1ns / 1ps

module tb;
  import afpf_pkg::*;

  // one pixel test or pattern load request, as carried on the input channel
  typedef struct {
    logic [1:0]         mode;
    logic [9:0]         px;
    logic [9:0]         py;
    logic signed [15:0] shx;
    logic signed [15:0] shy;
    logic [14:0]        sw;
    logic [14:0]        sh;
    logic               white;
    logic               pat;
    logic [11:0]        li;
    logic               lb;
  } fill_req_t;

  // one covered pixel as it should appear on the result channel
  typedef struct {
    logic [9:0] x;
    logic [9:0] y;
    logic       white;
  } pixel_t;

  localparam longint ONE_Q = 64'sd1 <<< 17;   // 1.0 in logical q17
  localparam int CELLS = 4096;

  // coverage and colour predictor plus the queue of covered pixels still owed
  class fill_scoreboard;
    longint   mtx[6];
    longint   tile_w;
    longint   tile_h;
    bit       store[CELLS];
    bit       loaded[CELLS];
    pixel_t   owed[$];
    int       errors;

    function new();
      mtx = '{65536, 0, 0, 65536, 0, 0};
      tile_w = 0;
      tile_h = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        CFG_TILE_W: tile_w = val[6:0];
        CFG_TILE_H: tile_h = val[6:0];
        default: mtx[idx] = longint'($signed(val));
      endcase
    endfunction

    // pixel centre mapped back to logical space, exact in q17
    function void to_logical(logic [9:0] px, logic [9:0] py, output longint lx,
                             output longint ly);
      longint sx2, sy2;
      sx2 = 2 * longint'(px) + 1;
      sy2 = 2 * longint'(py) + 1;
      lx = mtx[0] * sx2 + mtx[2] * sy2 + 2 * mtx[4];
      ly = mtx[1] * sx2 + mtx[3] * sy2 + 2 * mtx[5];
    endfunction

    function bit covers(fill_req_t r, longint lx, longint ly);
      longint x0, y0, dx, dy;
      logic [127:0] d2, rr;
      x0 = longint'(r.shx) * ONE_Q;
      y0 = longint'(r.shy) * ONE_Q;
      if (r.mode == MODE_RECT) begin
        return r.sw != 0 && r.sh != 0 && lx >= x0 && lx < x0 + longint'(r.sw) * ONE_Q &&
               ly >= y0 && ly < y0 + longint'(r.sh) * ONE_Q;
      end
      if (r.mode != MODE_DISC || r.sw == 0) return 0;
      dx = lx - x0;
      dy = ly - y0;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      d2 = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
      rr = 128'(longint'(r.sw) * ONE_Q);
      return d2 <= rr * rr;
    endfunction

    // tiled pattern cell address; floor toward minus infinity, positive remainder
    function longint cell_of(longint lx, longint ly);
      longint cx, cy;
      cx = (lx >>> 17) % tile_w;
      cy = (ly >>> 17) % tile_h;
      if (cx < 0) cx += tile_w;
      if (cy < 0) cy += tile_h;
      return cy * tile_w + cx;
    endfunction

    // true when this request would read a pattern cell that was never loaded
    function bit reads_unloaded(fill_req_t r);
      longint lx, ly, c;
      if (r.mode == MODE_LOAD || !r.pat || tile_w == 0 || tile_h == 0) return 0;
      to_logical(r.px, r.py, lx, ly);
      if (!covers(r, lx, ly)) return 0;
      c = cell_of(lx, ly);
      return c < CELLS && !loaded[c];
    endfunction

    function void note_request(fill_req_t r);
      longint lx, ly, c;
      pixel_t p;
      if (r.mode == MODE_LOAD) begin
        store[r.li] = r.lb;
        loaded[r.li] = 1;
        return;
      end
      to_logical(r.px, r.py, lx, ly);
      if (!covers(r, lx, ly)) return;
      p.x = r.px;
      p.y = r.py;
      if (!r.pat) p.white = r.white;
      else if (tile_w == 0 || tile_h == 0) p.white = 1;
      else begin
        c = cell_of(lx, ly);
        if (c >= CELLS) p.white = !r.white;
        else p.white = r.white ? store[c] : !store[c];
      end
      owed.push_back(p);
    endfunction

    function void check_result(logic [23:0] d);
      pixel_t p;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d white=%0d", $time, d[9:0], d[19:10],
                 d[20]);
        errors++;
        return;
      end
      p = owed.pop_front();
      if (d[9:0] !== p.x || d[19:10] !== p.y || d[20] !== p.white || d[23:21] !== 3'b0) begin
        $display("%0t: mismatch expected x=%0d y=%0d white=%0d got x=%0d y=%0d white=%0d pad=%0h",
                 $time, p.x, p.y, p.white, d[9:0], d[19:10], d[20], d[23:21]);
        errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [103:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [23:0]  out_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_data;

  fill_scoreboard pix_sb;
  int in_idle_pct;      // sender idle percentage for the current phase
  int out_stall_pct;    // receiver stall percentage for the current phase
  int hold_off;         // long receiver hold-off, counted down by the receiver
  int quiet_cycles;

  affine_pattern_fill_pixel_test_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls per phase, plus the long hold-off when asked
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_tready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= out_stall_pct);
    end
  end

  // result monitor, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) pix_sb.check_result(out_tdata);
  end

  // watchdog: ends the run after a long stretch with no request moving anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 5000) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // drive one request; gaps come before it at the sender's idle rate
  task automatic send_req(fill_req_t r);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= r.mode;
    in_tdata  <= {7'b0, r.lb, r.li, r.pat, r.white, r.sh, r.sw, r.shy, r.shx, r.py, r.px};
    do @(posedge clk); while (!in_tready);
    pix_sb.note_request(r);
  endtask

  task automatic send_fields(logic [1:0] mode, int px, int py, int shx, int shy, int sw,
                             int sh, bit white, bit pat, int li, bit lb);
    fill_req_t r;
    r = '{mode, 10'(px), 10'(py), 16'(shx), 16'(shy), 15'(sw), 15'(sh), white, pat,
          12'(li), lb};
    send_req(r);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // sender pauses until every owed pixel is back, then lets loads and misses drain
  task automatic drain();
    stop_sending();
    while (pix_sb.owed.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    pix_sb.set_reg(idx, val);
  endtask

  task automatic set_mapping(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d,
                             logic [31:0] e, logic [31:0] f, int tw, int th);
    drain();
    write_reg(CFG_INV_A, a);
    write_reg(CFG_INV_B, b);
    write_reg(CFG_INV_C, c);
    write_reg(CFG_INV_D, d);
    write_reg(CFG_INV_E, e);
    write_reg(CFG_INV_F, f);
    write_reg(CFG_TILE_W, tw);
    write_reg(CFG_TILE_H, th);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // load up to n pattern cells of the current tile with random bits
  task automatic load_tile(int n);
    int cells;
    cells = int'(pix_sb.tile_w * pix_sb.tile_h);
    if (cells > CELLS) cells = CELLS;
    for (int i = 0; i < cells && i < n; i++) begin
      send_fields(MODE_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  1'($urandom), 1'($urandom), (cells <= n) ? i : $urandom_range(0, cells - 1),
                  1'($urandom));
    end
  endtask

  // random request; most tests place the shape around the mapped pixel so hits happen
  function automatic fill_req_t random_req();
    fill_req_t r;
    longint lx, ly, fx, fy;
    int pick, span;
    r.px = 10'($urandom);
    r.py = 10'($urandom);
    r.shx = 16'($urandom);
    r.shy = 16'($urandom);
    r.sw = 15'($urandom);
    r.sh = 15'($urandom);
    r.white = 1'($urandom);
    r.pat = 1'($urandom);
    r.li = 12'($urandom);
    r.lb = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      r.mode = MODE_LOAD;
      span = int'(pix_sb.tile_w * pix_sb.tile_h);
      if (span > 0 && span <= CELLS && $urandom_range(0, 3) != 0)
        r.li = 12'($urandom_range(0, span - 1));
      return r;
    end
    if (pick < 18) begin
      r.mode = MODE_UNUSED;   // no effect
      return r;
    end
    r.mode = (pick < 60) ? MODE_RECT : MODE_DISC;
    case ($urandom_range(0, 9))
      0: r.sw = 0;
      1: r.sh = 0;
      2, 3: ;
      default: begin
        r.sw = 15'($urandom_range(1, 24));
        r.sh = 15'($urandom_range(1, 24));
      end
    endcase
    if ($urandom_range(0, 9) < 8) begin
      pix_sb.to_logical(r.px, r.py, lx, ly);
      fx = lx >>> 17;
      fy = ly >>> 17;
      if (r.mode == MODE_RECT) begin
        r.shx = 16'(fx - $urandom_range(0, (r.sw > 24) ? 24 : r.sw));
        r.shy = 16'(fy - $urandom_range(0, (r.sh > 24) ? 24 : r.sh));
      end else begin
        r.shx = 16'(fx + $signed($urandom_range(0, 20)) - 10);
        r.shy = 16'(fy + $signed($urandom_range(0, 20)) - 10);
      end
    end
    return r;
  endfunction

  task automatic random_phase(int n, int in_pct, int out_pct);
    fill_req_t r;
    in_idle_pct = in_pct;
    out_stall_pct = out_pct;
    for (int i = 0; i < n; i++) begin
      r = random_req();
      if (pix_sb.reads_unloaded(r)) r.pat = 0;
      send_req(r);
    end
  endtask

  initial begin
    pix_sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = MODE_LOAD;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_INV_A;
    cfg_data = '0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    hold_off = 0;
    quiet_cycles = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part at the reset mapping: pixel (5,7) lands on logical (5.5,7.5)
    send_fields(MODE_RECT, 5, 7, 5, 7, 1, 1, 1, 0, 0, 0);        // covered, white
    send_fields(MODE_RECT, 5, 7, 6, 7, 1, 1, 1, 0, 0, 0);        // left edge misses
    send_fields(MODE_RECT, 5, 7, 4, 7, 1, 1, 1, 0, 0, 0);        // right edge is open
    send_fields(MODE_RECT, 5, 7, 5, 7, 0, 1, 1, 0, 0, 0);        // empty width
    send_fields(MODE_RECT, 5, 7, 5, 7, 1, 0, 1, 0, 0, 0);        // empty height
    send_fields(MODE_RECT, 5, 7, 5, 7, 1, 1, 0, 0, 0, 0);        // solid black
    send_fields(MODE_RECT, 5, 7, 5, 7, 1, 1, 0, 1, 0, 0);        // empty tile gives white
    send_fields(MODE_DISC, 5, 7, 5, 7, 1, 0, 1, 0, 0, 0);        // disc hit
    send_fields(MODE_DISC, 5, 7, 4, 6, 1, 0, 1, 0, 0, 0);        // just outside the disc
    send_fields(MODE_DISC, 5, 7, 5, 7, 0, 7, 1, 0, 0, 0);        // zero radius
    send_fields(MODE_DISC, 0, 0, -32768, -32768, 32767, 0, 1, 1, 0, 0);
    send_fields(MODE_UNUSED, 5, 7, 5, 7, 1, 1, 1, 0, 0, 0);      // unused mode
    send_fields(MODE_RECT, 1023, 1023, -32768, -32768, 32767, 32767, 1, 0, 0, 0);
    send_fields(MODE_RECT, 1023, 1023, 1000, 1000, 32767, 32767, 1, 0, 0, 0);
    send_fields(MODE_RECT, 1023, 1023, 32767, 32767, 32767, 32767, 0, 0, 0, 0);
    send_fields(MODE_RECT, 0, 0, 0, 0, 1, 1, 1, 0, 0, 0);
    send_fields(MODE_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 4095, 1);
    send_fields(MODE_LOAD, 1023, 1023, -1, -1, 32767, 32767, 1, 1, 0, 0);
    send_fields(MODE_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1);

    // identity with an 8x8 tile; the receiver holds off while the sender keeps going
    set_mapping(32'd65536, 0, 0, 32'd65536, 0, 0, 8, 8);
    load_tile(64);
    hold_off = 400;
    random_phase(200, 0, 0);
    random_phase(100, 49, 0);

    // scale of two with an offset and an odd tile
    set_mapping(32'd131072, 0, 0, 32'd131072, -(32'sd3 <<< 16), 32'sd5 <<< 15, 5, 3);
    load_tile(15);
    random_phase(170, 0, 49);

    // quarter turn with translation, single cell tile
    set_mapping(0, -32'sd65536, 32'sd65536, 0, 32'sd1000 <<< 16, -32'sd77 <<< 16, 1, 1);
    load_tile(1);
    random_phase(170, 31, 31);

    // extreme coefficients and a 64x64 tile that fills the whole pattern store
    set_mapping(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'hffffffff,
                32'h7fffffff, 64, 64);
    load_tile(80);
    random_phase(120, 0, 0);

    // fractional shear with long thin tiles
    set_mapping(32'd32768, 32'd12345, -32'sd20000, 32'd40000, $urandom, $urandom, 64, 1);
    load_tile(64);
    random_phase(120, 49, 0);
    set_mapping(32'd49152, -32'sd7000, 32'd9000, 32'd65536, $urandom_range(0, 1 << 24),
                $urandom_range(0, 1 << 24), 3, 64);
    load_tile(192);
    random_phase(120, 31, 31);

    // empty tile again: pattern requests all come out white
    set_mapping(32'd65536, 0, 0, 32'd65536, 0, 0, 0, 7);
    random_phase(120, 0, 49);

    drain();
    if (pix_sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
